>>> src/sss_pkg.sv
// Shared constants and types of the SQL statement splitter.
package sss_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int CFG_W       = 24;
	localparam logic [CFG_W-1:0] MAX_LEN_RST = 24'd8388607;

	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);

	localparam logic [1:0] OC_CONT     = 2'd0;
	localparam logic [1:0] OC_COMMIT   = 2'd1;
	localparam logic [1:0] OC_DISCARD  = 2'd2;
	localparam logic [1:0] OC_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       has_byte;
		logic [1:0] outcome;
	} res_t;

	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} ent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> src/sss_parser.sv
// Front end: accepts script bytes, strips comments and marks kept bytes.
module sss_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    byte_in,
	input  logic                          end_of_input,
	input  logic                          cfg_valid,
	input  logic [sss_pkg::CFG_W-1:0]     max_length,
	input  sss_pkg::qstat_t               qstat,
	output logic                          push,
	output sss_pkg::ent_t                 push_ent
);
	import sss_pkg::*;

	localparam logic [1:0] HOLD_NONE  = 2'd0;
	localparam logic [1:0] HOLD_DASH  = 2'd1;
	localparam logic [1:0] HOLD_SLASH = 2'd2;
	localparam logic [1:0] HOLD_STAR  = 2'd3;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic                   quote;
		logic                   blk;
		logic                   line;
		logic [1:0]             held;
		logic [7:0]             last;
		logic [LENGTH_BITS-1:0] len;
		logic                   halted;
	} pst_t;

	typedef struct packed {
		pst_t st;
		res_t r;
	} kr_t;

	typedef struct packed {
		pst_t       st;
		res_t       r0;
		res_t       r1;
		logic [1:0] n;
	} step_t;

	pst_t                   st_q;
	logic [LENGTH_BITS-1:0] lim_q;
	step_t                  nx;
	logic                   acc;

	function automatic logic [LENGTH_BITS-1:0] lim_of(input logic [CFG_W-1:0] v);
		logic [32:0] vv;
		logic [32:0] cap;
		vv  = 33'(v);
		cap = (33'd1 << LENGTH_BITS) - 33'd1;
		return LENGTH_BITS'((vv < cap) ? vv : cap);
	endfunction

	function automatic kr_t keep(input pst_t si, input logic [7:0] b,
			input logic [LENGTH_BITS-1:0] lim);
		kr_t o;
		o.st = si;
		o.r  = '0;
		if (si.len >= lim) begin
			o.r.outcome  = OC_OVERFLOW;
			o.st.halted  = 1'b1;
		end else begin
			if (b == CH_QUOTE && (si.len == '0 || si.last != CH_BSL))
				o.st.quote = ~si.quote;
			o.st.len  = si.len + LENGTH_BITS'(1);
			o.st.last = b;
			o.r.byte_out = b;
			o.r.has_byte = 1'b1;
			if (!o.st.quote && b == CH_SEMI) begin
				o.r.outcome = (o.st.len > LENGTH_BITS'(1)) ? OC_COMMIT : OC_DISCARD;
				o.st.len    = '0;
				o.st.last   = 8'd0;
			end else begin
				o.r.outcome = OC_CONT;
			end
		end
		return o;
	endfunction

	function automatic step_t do_flush(input pst_t si, input logic [LENGTH_BITS-1:0] lim);
		step_t o;
		kr_t   k;
		res_t  e;
		o.st = si;
		o.r0 = '0;
		o.r1 = '0;
		o.n  = 2'd0;
		if (si.held == HOLD_DASH || si.held == HOLD_SLASH) begin
			o.st.held = HOLD_NONE;
			k = keep(o.st, (si.held == HOLD_DASH) ? CH_DASH : CH_SLASH, lim);
			o.st = k.st;
			o.r0 = k.r;
			o.n  = 2'd1;
		end
		if (!o.st.halted && o.st.len != '0) begin
			e.byte_out = 8'd0;
			e.has_byte = 1'b0;
			e.outcome  = (o.st.blk || o.st.line) ? OC_DISCARD : OC_COMMIT;
			if (o.n == 2'd0)
				o.r0 = e;
			else
				o.r1 = e;
			o.n = o.n + 2'd1;
		end
		return o;
	endfunction

	function automatic step_t do_handle(input pst_t si, input logic [7:0] b,
			input logic [LENGTH_BITS-1:0] lim);
		step_t o;
		kr_t   k;
		logic  done;
		logic  closed;
		o.st   = si;
		o.r0   = '0;
		o.r1   = '0;
		o.n    = 2'd0;
		done   = 1'b0;
		closed = 1'b0;
		if (si.blk) begin
			if (si.held == HOLD_STAR) begin
				o.st.held = HOLD_NONE;
				if (b == CH_SLASH) begin
					o.st.blk = 1'b0;
					closed   = 1'b1;
				end
			end
			if (!closed && b == CH_STAR)
				o.st.held = HOLD_STAR;
		end else if (si.line) begin
			if (b == CH_NL)
				o.st.line = 1'b0;
		end else begin
			if (si.held == HOLD_DASH || si.held == HOLD_SLASH) begin
				o.st.held = HOLD_NONE;
				if (si.held == HOLD_DASH && b == CH_DASH) begin
					o.st.line = 1'b1;
					done      = 1'b1;
				end else if (si.held == HOLD_SLASH && b == CH_STAR) begin
					o.st.blk = 1'b1;
					done     = 1'b1;
				end else begin
					k = keep(o.st, (si.held == HOLD_DASH) ? CH_DASH : CH_SLASH, lim);
					o.st = k.st;
					o.r0 = k.r;
					o.n  = 2'd1;
					done = k.st.halted;
				end
			end
			if (!done) begin
				if (!o.st.quote && b == CH_DASH) begin
					o.st.held = HOLD_DASH;
				end else if (!o.st.quote && b == CH_SLASH) begin
					o.st.held = HOLD_SLASH;
				end else begin
					k = keep(o.st, b, lim);
					if (o.n == 2'd0)
						o.r0 = k.r;
					else
						o.r1 = k.r;
					o.st = k.st;
					o.n  = o.n + 2'd1;
				end
			end
		end
		return o;
	endfunction

	always_comb begin
		nx.st = st_q;
		nx.r0 = '0;
		nx.r1 = '0;
		nx.n  = 2'd0;
		if (end_of_input) begin
			if (!st_q.halted)
				nx = do_flush(st_q, lim_q);
			nx.st = '0;
		end else if (!st_q.halted) begin
			if (byte_in == CH_NUL) begin
				nx = do_flush(st_q, lim_q);
				nx.st        = '0;
				nx.st.halted = 1'b1;
			end else begin
				nx = do_handle(st_q, byte_in, lim_q);
			end
		end
	end

	assign in_stall    = qstat.full;
	assign acc         = in_valid && !in_stall;
	assign push        = acc && (nx.n != 2'd0);
	assign push_ent.r0  = nx.r0;
	assign push_ent.r1  = nx.r1;
	assign push_ent.two = (nx.n == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			lim_q <= lim_of(MAX_LEN_RST);
		end else begin
			if (cfg_valid)
				lim_q <= lim_of(max_length);
			if (acc)
				st_q <= nx.st;
		end
	end

endmodule

>>> src/sss_queue.sv
// Short queue of result groups between the parser and the emitter.
module sss_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sss_pkg::ent_t   push_ent,
	input  logic            pop,
	output sss_pkg::ent_t   head,
	output sss_pkg::qstat_t qstat
);
	import sss_pkg::*;

	ent_t            mem_q [QDEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == QC_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_q + QA_W'(1);
			if (pop)
				rd_q <= (rd_q == QA_W'(QDEPTH - 1)) ? '0 : rd_q + QA_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QC_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QC_W'(1);
		end
	end

endmodule

>>> src/sss_emitter.sv
// Back end: serialises queued result groups into the output register.
module sss_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  sss_pkg::ent_t   head,
	input  sss_pkg::qstat_t qstat,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      byte_out,
	output logic            has_byte,
	output logic [1:0]      outcome
);
	import sss_pkg::*;

	logic out_valid_q;
	logic sel_q;
	res_t res_q;
	res_t cur;
	logic load;

	assign cur  = sel_q ? head.r1 : head.r0;
	assign load = !qstat.empty && (!out_valid_q || !out_stall);
	assign pop  = load && (sel_q || !head.two);

	always_ff @(posedge clk) begin
		if (load)
			res_q <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= !sel_q && head.two;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign byte_out  = res_q.byte_out;
	assign has_byte  = res_q.has_byte;
	assign outcome   = res_q.outcome;

endmodule

>>> src/sql_statement_splitter.sv
// Top level of the SQL statement splitter.
//
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------
// in       | in_valid / in_stall  | byte_in, end_of_input
// out      | out_valid / out_stall| byte_out, has_byte, outcome
// cfg      | cfg_valid / cfg_ready| max_length
//
// One input transaction per cycle while in_stall is low; a byte that yields two
// results sends them out one after the other, absorbed by a four-entry queue.
// A result reaches the output via a queue entry and then the output register.
// in_stall rises while the queue is full; out_stall holds the output register.
// Reset clears parser state and queue and loads max_length with 8388607.
module sql_statement_splitter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                byte_in,
	input  logic                      end_of_input,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                byte_out,
	output logic                      has_byte,
	output logic [1:0]                outcome,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sss_pkg::CFG_W-1:0] max_length
);
	import sss_pkg::*;

	logic   push;
	ent_t   push_ent;
	logic   pop;
	ent_t   head;
	qstat_t qst;

	assign cfg_ready = 1'b1;

	sss_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_in      (byte_in),
		.end_of_input (end_of_input),
		.cfg_valid    (cfg_valid),
		.max_length   (max_length),
		.qstat        (qst),
		.push         (push),
		.push_ent     (push_ent)
	);

	sss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.qstat    (qst)
	);

	sss_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qst),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.byte_out  (byte_out),
		.has_byte  (has_byte),
		.outcome   (outcome)
	);

	a_nobyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> byte_out == 8'd0)
		else $error("byte_out not zero on a transaction without a byte");

	a_cont_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OC_CONT |-> has_byte)
		else $error("continue transaction without a byte");

	a_ovf_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OC_OVERFLOW |-> !has_byte)
		else $error("overflow transaction carries a byte");

	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output register empty");

endmodule
